>>> sv/adam_pkg.sv
// Package for the Adam parameter update block.
// Holds the transaction payload types, register indexes and reset values.
// No dependencies.
package adam_pkg;

	localparam int unsigned NUM_ELEMENTS_DEF = 4096;
	localparam int unsigned DATA_WIDTH_DEF   = 32;

	// Register indexes on the configuration port.
	localparam logic [2:0] CFG_BETA_ONE  = 3'd0;
	localparam logic [2:0] CFG_BETA_TWO  = 3'd1;
	localparam logic [2:0] CFG_STEP_SIZE = 3'd2;
	localparam logic [2:0] CFG_DEN_FLOOR = 3'd3;

	// Register values after reset.
	localparam logic [15:0] BETA_ONE_RST  = 16'd58982;
	localparam logic [15:0] BETA_TWO_RST  = 16'd65470;
	localparam logic [23:0] STEP_SIZE_RST = 24'd16777;
	localparam logic [23:0] DEN_FLOOR_RST = 24'd1;

	typedef struct packed {
		logic        [11:0] element_index;
		logic signed [31:0] param_value;
		logic signed [31:0] gradient_value;
		logic               step_start;
	} item_t;

	typedef struct packed {
		logic        [11:0] result_index;
		logic signed [31:0] new_param;
		logic               saturated;
	} result_t;

endpackage

>>> sv/adam_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module adam_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/adam_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Carries a sideband word alongside each division. No dependencies.
module adam_div #(
	parameter int unsigned NW = 64,
	parameter int unsigned DW = 33,
	parameter int unsigned QW = 32,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] sb_in,
	output logic [QW-1:0] quot,
	output logic          ovf,
	output logic [SW-1:0] sb_out
);

	logic [NW-1:0] hi;
	logic [DW-1:0] rem_q [0:QW-1];
	logic [DW-1:0] den_q [0:QW-1];
	logic [QW-1:0] lo_q  [0:QW-1];
	logic [QW-1:0] quo_q [0:QW-1];
	logic          ovf_q [0:QW-1];
	logic [SW-1:0] sb_q  [0:QW-1];

	logic [DW-1:0] nrem [0:QW-1];
	logic [DW-1:0] nden [0:QW-1];
	logic [QW-1:0] nlo  [0:QW-1];
	logic [QW-1:0] nquo [0:QW-1];
	logic          novf [0:QW-1];
	logic [SW-1:0] nsb  [0:QW-1];

	assign hi = num >> QW;

	always_comb begin
		logic [DW-1:0] cr;
		logic [DW-1:0] cd;
		logic [QW-1:0] cl;
		logic [QW-1:0] cq;
		logic          co;
		logic [SW-1:0] cs;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				cr = hi[DW-1:0];
				cd = den;
				cl = num[QW-1:0];
				cq = '0;
				co = (hi >= NW'(den));
				cs = sb_in;
			end else begin
				cr = rem_q[k-1];
				cd = den_q[k-1];
				cl = lo_q[k-1];
				cq = quo_q[k-1];
				co = ovf_q[k-1];
				cs = sb_q[k-1];
			end
			trial   = {cr, cl[QW-1]};
			diff    = trial - {1'b0, cd};
			ge      = (trial >= {1'b0, cd});
			nrem[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
			nden[k] = cd;
			nlo[k]  = {cl[QW-2:0], 1'b0};
			nquo[k] = {cq[QW-2:0], ge};
			novf[k] = co;
			nsb[k]  = cs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) begin
				sb_q[k] <= '0;
			end
		end else if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_q[k] <= nrem[k];
				den_q[k] <= nden[k];
				lo_q[k]  <= nlo[k];
				quo_q[k] <= nquo[k];
				ovf_q[k] <= novf[k];
				sb_q[k]  <= nsb[k];
			end
		end
	end

	assign quot   = quo_q[QW-1];
	assign ovf    = ovf_q[QW-1];
	assign sb_out = sb_q[QW-1];

endmodule

>>> sv/adam_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Carries a sideband word alongside each operand. No dependencies.
module adam_sqrt #(
	parameter int unsigned XW = 64,
	parameter int unsigned SW = 1,
	parameter int unsigned RW = XW / 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [XW-1:0] x,
	input  logic [SW-1:0] sb_in,
	output logic [RW-1:0] root,
	output logic [SW-1:0] sb_out
);

	logic [RW+1:0] rem_q [0:RW-1];
	logic [RW-1:0] rt_q  [0:RW-1];
	logic [XW-1:0] x_q   [0:RW-1];
	logic [SW-1:0] sb_q  [0:RW-1];

	logic [RW+1:0] nrem [0:RW-1];
	logic [RW-1:0] nrt  [0:RW-1];
	logic [XW-1:0] nx   [0:RW-1];
	logic [SW-1:0] nsb  [0:RW-1];

	always_comb begin
		logic [RW+1:0] cr;
		logic [RW-1:0] ct;
		logic [XW-1:0] cx;
		logic [SW-1:0] cs;
		logic [RW+3:0] acc;
		logic [RW+3:0] trial;
		logic [RW+3:0] diff;
		logic          ge;
		for (int k = 0; k < RW; k++) begin
			if (k == 0) begin
				cr = '0;
				ct = '0;
				cx = x;
				cs = sb_in;
			end else begin
				cr = rem_q[k-1];
				ct = rt_q[k-1];
				cx = x_q[k-1];
				cs = sb_q[k-1];
			end
			acc     = {cr, cx[XW-1:XW-2]};
			trial   = {2'b00, ct, 2'b01};
			diff    = acc - trial;
			ge      = (acc >= trial);
			nrem[k] = ge ? diff[RW+1:0] : acc[RW+1:0];
			nrt[k]  = {ct[RW-2:0], ge};
			nx[k]   = {cx[XW-3:0], 2'b00};
			nsb[k]  = cs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RW; k++) begin
				sb_q[k] <= '0;
			end
		end else if (en) begin
			for (int k = 0; k < RW; k++) begin
				rem_q[k] <= nrem[k];
				rt_q[k]  <= nrt[k];
				x_q[k]   <= nx[k];
				sb_q[k]  <= nsb[k];
			end
		end
	end

	assign root   = rt_q[RW-1];
	assign sb_out = sb_q[RW-1];

endmodule

>>> sv/adam_parameter_update.sv
// Top level of the Adam parameter update block.
// Depends on adam_pkg, adam_ram, adam_div and adam_sqrt.
//
// Usage: items arrive on the item channel (item_valid, item_stall, item) and
// one result leaves per item on the result channel (result_valid,
// result_stall, result), in order. A transaction on either channel completes
// at a rising edge where valid is high and stall is low. Registers are
// written through the cfg channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and writes should happen while the
// block holds no items in flight.
// Throughput is one item per cycle while item_stall is low. From the item
// transaction to result_valid, an item passes the moment read-modify-write
// (the read is issued at the transaction edge), the moment magnitude
// register, the first-moment bias correction divider, the second-moment
// divider, the square root, the step-size multiply, the final divider and
// the output register.
// Reset clears the registers to their defaults, sets the beta powers to one
// and marks the first step, during which the moment memories read as zero;
// the memories themselves are not cleared.
// When the receiver stalls, the result waits in the output register and one
// more result lands in a skid register; item_stall then rises and the whole
// pipeline holds until the skid register drains.
module adam_parameter_update import adam_pkg::*; #(
	parameter int unsigned NUM_ELEMENTS = NUM_ELEMENTS_DEF,
	parameter int unsigned DATA_WIDTH   = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
	localparam logic signed [65:0] HI_LIM = (66'sd1 <<< (DATA_WIDTH - 1)) - 66'sd1;
	localparam logic signed [65:0] LO_LIM = -HI_LIM - 66'sd1;

	// Sideband words that ride along with the long arithmetic units.
	typedef struct packed {
		logic               valid;
		logic        [11:0] idx;
		logic signed [31:0] param;
		logic               neg;
		logic        [47:0] v;
		logic        [31:0] p2;
	} sb_mh_t;

	typedef struct packed {
		logic               valid;
		logic        [11:0] idx;
		logic signed [31:0] param;
		logic               neg;
		logic        [62:0] mh;
	} sb_vh_t;

	typedef struct packed {
		logic               valid;
		logic        [11:0] idx;
		logic signed [31:0] param;
		logic               neg;
	} sb_fin_t;

	// Configuration registers.
	logic [15:0] beta_one_q;
	logic [15:0] beta_two_q;
	logic [23:0] step_size_q;
	logic [23:0] den_floor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_one_q  <= BETA_ONE_RST;
			beta_two_q  <= BETA_TWO_RST;
			step_size_q <= STEP_SIZE_RST;
			den_floor_q <= DEN_FLOOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BETA_ONE:  beta_one_q  <= cfg_data[15:0];
				CFG_BETA_TWO:  beta_two_q  <= cfg_data[15:0];
				CFG_STEP_SIZE: step_size_q <= cfg_data;
				CFG_DEN_FLOOR: den_floor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together; it holds only while the skid
	// register is occupied, so the enable comes straight from a flop.
	logic skid_valid_q;
	logic en;
	logic accept;

	assign en         = !skid_valid_q;
	assign item_stall = skid_valid_q;
	assign accept     = item_valid && en;

	// Wrap the index into the store by subtracting shifted copies of the depth.
	logic [31:0] red_idx;
	logic [AW-1:0] addr_in;

	always_comb begin
		red_idx = {20'b0, item.element_index};
		for (int k = 11; k >= 0; k--) begin
			if (red_idx >= (32'(NUM_ELEMENTS) << k)) begin
				red_idx = red_idx - (32'(NUM_ELEMENTS) << k);
			end
		end
	end

	assign addr_in = red_idx[AW-1:0];

	// Beta powers and the first-step mark advance on a step start, before the
	// item that carries the step start uses them.
	logic [31:0] p1_q;
	logic [31:0] p2_q;
	logic        mark_q;
	logic        begun_q;
	logic [47:0] p1_prod;
	logic [47:0] p2_prod;
	logic [31:0] p1_next;
	logic [31:0] p2_next;
	logic        mark_next;

	assign p1_prod   = {16'b0, p1_q} * {32'b0, beta_one_q};
	assign p2_prod   = {16'b0, p2_q} * {32'b0, beta_two_q};
	assign p1_next   = item.step_start ? p1_prod[47:16] : p1_q;
	assign p2_next   = item.step_start ? p2_prod[47:16] : p2_q;
	assign mark_next = (item.step_start && begun_q) ? 1'b0 : mark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q    <= '1;
			p2_q    <= '1;
			mark_q  <= 1'b1;
			begun_q <= 1'b0;
		end else if (accept) begin
			p1_q   <= p1_next;
			p2_q   <= p2_next;
			mark_q <= mark_next;
			if (item.step_start) begin
				begun_q <= 1'b1;
			end
		end
	end

	// Gradient square, computed on the way into the first stage.
	logic [31:0] gmag_in;
	logic [63:0] gsq_in;

	assign gmag_in = item.gradient_value[31] ? 32'(-item.gradient_value)
	                                         : item.gradient_value;
	assign gsq_in  = {32'b0, gmag_in} * {32'b0, gmag_in};

	// Stage 1: moment memories return data; new moments are formed and
	// written back in the same cycle.
	logic               valid_s1;
	logic        [11:0] idx_s1;
	logic [AW-1:0]      addr_s1;
	logic signed [31:0] param_s1;
	logic signed [31:0] grad_s1;
	logic        [47:0] g2_s1;
	logic               mark_s1;
	logic        [31:0] p1_s1;
	logic        [31:0] p2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= item.element_index;
			addr_s1  <= addr_in;
			param_s1 <= item.param_value;
			grad_s1  <= item.gradient_value;
			g2_s1    <= gsq_in[63:16];
			mark_s1  <= mark_next;
			p1_s1    <= p1_next;
			p2_s1    <= p2_next;
		end
	end

	logic signed [31:0] m_rd;
	logic        [47:0] v_rd;
	logic signed [31:0] m_new;
	logic        [47:0] v_new;
	logic               mem_we;

	assign mem_we = en && valid_s1;

	adam_ram #(
		.WIDTH(32),
		.DEPTH(NUM_ELEMENTS),
		.AW   (AW)
	) u_m_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(addr_s1),
		.wdata(m_new),
		.re   (accept),
		.raddr(addr_in),
		.rdata(m_rd)
	);

	adam_ram #(
		.WIDTH(48),
		.DEPTH(NUM_ELEMENTS),
		.AW   (AW)
	) u_v_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(addr_s1),
		.wdata(v_new),
		.re   (accept),
		.raddr(addr_in),
		.rdata(v_rd)
	);

	// The item ahead writes at the same edge this item reads, so the read
	// returns the old entry; the forwarding register captures that write.
	logic               fwd_valid_q;
	logic [AW-1:0]      fwd_addr_q;
	logic signed [31:0] fwd_m_q;
	logic        [47:0] fwd_v_q;
	logic               fwd_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (accept) begin
			fwd_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_addr_q <= addr_s1;
			fwd_m_q    <= m_new;
			fwd_v_q    <= v_new;
		end
	end

	assign fwd_hit = fwd_valid_q && (fwd_addr_q == addr_s1);

	logic signed [31:0] m_old;
	logic        [47:0] v_old;
	logic signed [16:0] b1_s;
	logic signed [17:0] b1c_s;
	logic        [16:0] b2c;
	logic signed [49:0] sum1;
	logic        [64:0] sum2;

	assign m_old = mark_s1 ? 32'sd0 : (fwd_hit ? fwd_m_q : m_rd);
	assign v_old = mark_s1 ? 48'd0  : (fwd_hit ? fwd_v_q : v_rd);
	assign b1_s  = $signed({1'b0, beta_one_q});
	assign b1c_s = $signed({1'b0, 17'h10000 - {1'b0, beta_one_q}});
	assign b2c   = 17'h10000 - {1'b0, beta_two_q};
	assign sum1  = b1_s * m_old + b1c_s * grad_s1;
	assign sum2  = {49'b0, beta_two_q} * {17'b0, v_old} + {48'b0, b2c} * {17'b0, g2_s1};
	assign m_new = sum1[47:16];
	assign v_new = sum2[63:16];

	// Stage 2: moment magnitude and sign, feeding the bias correction.
	logic               valid_s2;
	logic        [11:0] idx_s2;
	logic signed [31:0] param_s2;
	logic               neg_s2;
	logic        [31:0] m_mag_s2;
	logic        [47:0] v_s2;
	logic        [31:0] p1_s2;
	logic        [31:0] p2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2   <= idx_s1;
			param_s2 <= param_s1;
			neg_s2   <= m_new[31];
			m_mag_s2 <= m_new[31] ? 32'(-m_new) : m_new;
			v_s2     <= v_new;
			p1_s2    <= p1_s1;
			p2_s2    <= p2_s1;
		end
	end

	// First moment bias correction: |m| * 2^32 / (2^32 - beta_one_power).
	sb_mh_t      sb_mh_in;
	sb_mh_t      sb_mh_out;
	logic [62:0] mh_q;
	logic        mh_ovf;
	logic [62:0] mh;

	assign sb_mh_in = '{valid: valid_s2, idx: idx_s2, param: param_s2, neg: neg_s2,
	                    v: v_s2, p2: p2_s2};

	adam_div #(
		.NW(64),
		.DW(33),
		.QW(63),
		.SW($bits(sb_mh_t))
	) u_mh_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.num   ({m_mag_s2, 32'b0}),
		.den   (33'h1_0000_0000 - {1'b0, p1_s2}),
		.sb_in (sb_mh_in),
		.quot  (mh_q),
		.ovf   (mh_ovf),
		.sb_out(sb_mh_out)
	);

	assign mh = mh_ovf ? '1 : mh_q;

	// Second moment bias correction, saturated to 48 bits.
	sb_vh_t      sb_vh_in;
	sb_vh_t      sb_vh_out;
	logic [47:0] vh_q;
	logic        vh_ovf;
	logic [47:0] vh;

	assign sb_vh_in = '{valid: sb_mh_out.valid, idx: sb_mh_out.idx,
	                    param: sb_mh_out.param, neg: sb_mh_out.neg, mh: mh};

	adam_div #(
		.NW(80),
		.DW(33),
		.QW(48),
		.SW($bits(sb_vh_t))
	) u_vh_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.num   ({sb_mh_out.v, 32'b0}),
		.den   (33'h1_0000_0000 - {1'b0, sb_mh_out.p2}),
		.sb_in (sb_vh_in),
		.quot  (vh_q),
		.ovf   (vh_ovf),
		.sb_out(sb_vh_out)
	);

	assign vh = vh_ovf ? '1 : vh_q;

	// Square root of the corrected second moment, giving Q8.24.
	sb_vh_t      sb_rt_out;
	logic [31:0] root;

	adam_sqrt #(
		.XW(64),
		.SW($bits(sb_vh_t))
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.x     ({vh, 16'b0}),
		.sb_in (sb_vh_out),
		.root  (root),
		.sb_out(sb_rt_out)
	);

	// Stage 3: denominator and the step-size product, split in two halves.
	logic [32:0] den_sum;
	logic [32:0] den_use;

	assign den_sum = {1'b0, root} + {9'b0, den_floor_q};
	assign den_use = (den_sum == 33'd0) ? 33'd1 : den_sum;

	logic               valid_s3;
	logic        [11:0] idx_s3;
	logic signed [31:0] param_s3;
	logic               neg_s3;
	logic        [55:0] pplo_s3;
	logic        [54:0] pphi_s3;
	logic        [32:0] den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= sb_rt_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3   <= sb_rt_out.idx;
			param_s3 <= sb_rt_out.param;
			neg_s3   <= sb_rt_out.neg;
			pplo_s3  <= {24'b0, sb_rt_out.mh[31:0]} * {32'b0, step_size_q};
			pphi_s3  <= {24'b0, sb_rt_out.mh[62:32]} * {31'b0, step_size_q};
			den_s3   <= den_use;
		end
	end

	// Final division, capped at 2^32.
	sb_fin_t     sb_fin_in;
	sb_fin_t     sb_fin_out;
	logic [86:0] num_fin;
	logic [31:0] upd_q;
	logic        upd_ovf;
	logic [32:0] upd;

	assign num_fin   = {pphi_s3, 32'b0} + {31'b0, pplo_s3};
	assign sb_fin_in = '{valid: valid_s3, idx: idx_s3, param: param_s3, neg: neg_s3};

	adam_div #(
		.NW(87),
		.DW(33),
		.QW(32),
		.SW($bits(sb_fin_t))
	) u_fin_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.num   (num_fin),
		.den   (den_s3),
		.sb_in (sb_fin_in),
		.quot  (upd_q),
		.ovf   (upd_ovf),
		.sb_out(sb_fin_out)
	);

	assign upd = upd_ovf ? 33'h1_0000_0000 : {1'b0, upd_q};

	// Apply the update against the sign of the first moment and clip.
	logic signed [65:0] par_w;
	logic signed [65:0] upd_w;
	logic signed [65:0] newp;
	result_t            res_next;

	assign par_w = 66'(sb_fin_out.param);
	assign upd_w = $signed({33'b0, upd});
	assign newp  = sb_fin_out.neg ? (par_w + upd_w) : (par_w - upd_w);

	always_comb begin
		res_next.result_index = sb_fin_out.idx;
		res_next.saturated    = 1'b0;
		res_next.new_param    = newp[31:0];
		if (newp > HI_LIM) begin
			res_next.new_param = HI_LIM[31:0];
			res_next.saturated = 1'b1;
		end else if (newp < LO_LIM) begin
			res_next.new_param = LO_LIM[31:0];
			res_next.saturated = 1'b1;
		end
	end

	// Output register with a skid register behind it.
	logic    out_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_taken;

	assign out_taken = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_taken) begin
				out_q        <= skid_q;
				skid_valid_q <= 1'b0;
			end
		end else if (sb_fin_out.valid) begin
			if (!out_valid_q || out_taken) begin
				out_q       <= res_next;
				out_valid_q <= 1'b1;
			end else begin
				skid_q       <= res_next;
				skid_valid_q <= 1'b1;
			end
		end else if (out_taken) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
